### hdl/fsbm_pkg.sv
// shared types, codes and helpers for the flash/sram bus memory
package fsbm_pkg;

  typedef enum logic [3:0] {
    CMD_RD_BYTE = 4'd0,
    CMD_RD_HALF = 4'd1,
    CMD_RD_WORD = 4'd2,
    CMD_WR_BYTE = 4'd3,
    CMD_WR_HALF = 4'd4,
    CMD_WR_WORD = 4'd5,
    CMD_CK_HALF = 4'd6,
    CMD_CK_WORD = 4'd7,
    CMD_PROG    = 4'd8
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FCHK,
    S_SCHK,
    S_PERI,
    S_RD,
    S_RDW,
    S_WR,
    S_OUT
  } state_t;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_MISALIGN = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [0:0] REG_FLASH_BASE = 1'b0;
  localparam logic [0:0] REG_SRAM_BASE  = 1'b1;

  localparam logic [31:0] FLASH_BASE_RST = 32'h0800_0000;
  localparam logic [31:0] SRAM_BASE_RST  = 32'h2000_0000;

  localparam logic [31:0] PERIPH_LOW   = 32'h4000_0000;
  localparam logic [31:0] PERIPH_END   = 32'h4001_3000;
  localparam logic [31:0] PERIPH_LIMIT = PERIPH_END - PERIPH_LOW - 32'd1;

  // bytes moved by an access
  function automatic logic [2:0] byte_count(input cmd_t cmd);
    logic [2:0] n;
    unique case (cmd)
      CMD_RD_BYTE, CMD_WR_BYTE:              n = 3'd1;
      CMD_RD_HALF, CMD_WR_HALF, CMD_CK_HALF: n = 3'd2;
      default:                               n = 3'd4;
    endcase
    return n;
  endfunction

  // all-ones error pattern of the access width
  function automatic logic [31:0] err_pattern(input logic [2:0] n);
    logic [31:0] v;
    unique case (n)
      3'd1:    v = 32'h0000_00FF;
      3'd2:    v = 32'h0000_FFFF;
      default: v = 32'hFFFF_FFFF;
    endcase
    return v;
  endfunction

endpackage

### hdl/fsbm_ram.sv
// byte-wide single-port memory with registered read data
module fsbm_ram #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [7:0]               wdata,
  output logic [7:0]               rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/fsbm_span.sv
// shared offset subtractor and limit compare
module fsbm_span (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] lim,
  output logic [31:0] diff,
  output logic        ok
);

  // offset wraps modulo 2^32, so a region may straddle the top of memory
  assign diff = a - b;
  assign ok   = (diff <= lim);

endmodule

### hdl/flash_sram_bus_memory.sv
// top level: sequencer, config registers, shared span unit and the two byte stores
// flow: an access passes the flash and sram checks, then a read and read-wait step per
//   byte for reads, a write step per byte for writes and programming, or the peripheral
//   check; then the output step (direct on errors); in_tready only in the idle state
// reset: synchronous active-low; afterwards both stores are zeroed by a clearing pass
//   of max(FLASH_BYTES, SRAM_BYTES) entries, in_tready low (config writes still taken)
module flash_sram_bus_memory #(
  parameter int FLASH_BYTES = 65536,
  parameter int SRAM_BYTES  = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] address, [63:32] write_data
  input  logic [3:0]  in_tuser,   // [3:0] command
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_data
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fsbm_pkg::*;

  localparam int FAW = $clog2(FLASH_BYTES);
  localparam int SAW = $clog2(SRAM_BYTES);
  localparam int CLR_N = (FLASH_BYTES > SRAM_BYTES) ? FLASH_BYTES : SRAM_BYTES;
  localparam int CW = $clog2(CLR_N);
  localparam logic [31:0] FLASH_SZ = 32'(FLASH_BYTES);
  localparam logic [31:0] SRAM_SZ  = 32'(SRAM_BYTES);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);

  // sequencer state
  state_t        state_r, state_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [31:0]   data_r, data_nxt;
  logic [31:0]   baddr_r, baddr_nxt;     // address of the byte in hand
  logic [1:0]    idx_r, idx_nxt;         // byte lane in hand
  logic          fit_flash_r, fit_flash_nxt;
  logic          use_flash_r, use_flash_nxt;
  logic [31:0]   rd_r, rd_nxt;
  logic [1:0]    st_r, st_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic [1:0]    out_st_r, out_st_nxt;

  // config registers
  logic [31:0]   flash_base_r, flash_base_nxt;
  logic [31:0]   sram_base_r, sram_base_nxt;

  // shared span unit
  logic [31:0]   sp_a, sp_b, sp_lim, sp_diff;
  logic          sp_ok;

  // store ports
  logic          fl_we, sr_we;
  logic [FAW-1:0] fl_addr;
  logic [SAW-1:0] sr_addr;
  logic [7:0]    wbyte, fl_rdata, sr_rdata, rbyte;

  logic [2:0]    n;
  logic          last;
  logic          misal;
  logic          cfg_wr;
  logic [31:0]   n32;

  fsbm_span u_span (
    .a    (sp_a),
    .b    (sp_b),
    .lim  (sp_lim),
    .diff (sp_diff),
    .ok   (sp_ok)
  );

  fsbm_ram #(.DEPTH(FLASH_BYTES)) u_flash (
    .clk   (clk),
    .we    (fl_we),
    .addr  (fl_addr),
    .wdata (wbyte),
    .rdata (fl_rdata)
  );

  fsbm_ram #(.DEPTH(SRAM_BYTES)) u_sram (
    .clk   (clk),
    .we    (sr_we),
    .addr  (sr_addr),
    .wdata (wbyte),
    .rdata (sr_rdata)
  );

  assign n     = byte_count(cmd_r);
  assign n32   = {29'd0, n};
  assign last  = (idx_r == 2'(n - 3'd1));
  assign misal = ((addr_r[1:0] & 2'(n - 3'd1)) != 2'd0);
  assign rbyte = use_flash_r ? fl_rdata : sr_rdata;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

  // apb: always ready, register index from the word address
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SRAM_BASE) ? sram_base_r : flash_base_r;

  always_comb begin
    flash_base_nxt = flash_base_r;
    sram_base_nxt  = sram_base_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_FLASH_BASE: flash_base_nxt = cfg_pwdata;
        REG_SRAM_BASE:  sram_base_nxt  = cfg_pwdata;
        default:        flash_base_nxt = flash_base_r;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    baddr_nxt     = baddr_r;
    idx_nxt       = idx_r;
    fit_flash_nxt = fit_flash_r;
    use_flash_nxt = use_flash_r;
    rd_nxt        = rd_r;
    st_nxt        = st_r;
    out_data_nxt  = out_data_r;
    out_st_nxt    = out_st_r;
    out_valid_nxt = out_valid_r && !out_tready;

    sp_a   = baddr_r;
    sp_b   = use_flash_r ? flash_base_r : sram_base_r;
    sp_lim = (use_flash_r ? FLASH_SZ : SRAM_SZ) - 32'd1;

    fl_we   = 1'b0;
    sr_we   = 1'b0;
    fl_addr = sp_diff[FAW-1:0];
    sr_addr = sp_diff[SAW-1:0];
    wbyte   = data_r[{idx_r, 3'b000} +: 8];

    unique case (state_r)
      S_CLEAR: begin
        // zero one entry of each store per cycle
        fl_addr = clr_r[FAW-1:0];
        sr_addr = clr_r[SAW-1:0];
        wbyte   = 8'd0;
        fl_we   = (32'(clr_r) < FLASH_SZ);
        sr_we   = (32'(clr_r) < SRAM_SZ);
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = cmd_t'(in_tuser);
          addr_nxt  = in_tdata[31:0];
          data_nxt  = in_tdata[63:32];
          baddr_nxt = in_tdata[31:0];
          idx_nxt   = 2'd0;
          rd_nxt    = 32'd0;
          st_nxt    = ST_DONE;
          state_nxt = S_FCHK;
        end
      end

      S_FCHK: begin
        // whole span inside flash
        sp_a          = addr_r;
        sp_b          = flash_base_r;
        sp_lim        = FLASH_SZ - n32;
        fit_flash_nxt = sp_ok;
        state_nxt     = S_SCHK;
      end

      S_SCHK: begin
        // whole span inside sram, then dispatch on the command
        sp_a   = addr_r;
        sp_b   = sram_base_r;
        sp_lim = SRAM_SZ - n32;
        unique case (cmd_r)
          CMD_RD_BYTE, CMD_RD_HALF, CMD_RD_WORD: begin
            if (fit_flash_r) begin
              use_flash_nxt = 1'b1;
              state_nxt     = S_RD;
            end else if (sp_ok) begin
              use_flash_nxt = 1'b0;
              state_nxt     = S_RD;
            end else begin
              state_nxt = S_PERI;
            end
          end
          CMD_WR_BYTE, CMD_WR_HALF, CMD_WR_WORD: begin
            use_flash_nxt = 1'b0;
            state_nxt     = S_WR;
          end
          CMD_CK_HALF, CMD_CK_WORD: begin
            use_flash_nxt = 1'b0;
            if (misal) begin
              st_nxt    = ST_MISALIGN;
              state_nxt = S_OUT;
            end else if (!sp_ok) begin
              st_nxt    = ST_RANGE;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_WR;
            end
          end
          CMD_PROG: begin
            use_flash_nxt = 1'b1;
            state_nxt     = S_WR;
          end
          default: begin
            st_nxt    = ST_RANGE;
            state_nxt = S_OUT;
          end
        endcase
      end

      S_PERI: begin
        // word reads in the peripheral window answer zero
        sp_a   = addr_r;
        sp_b   = PERIPH_LOW;
        sp_lim = PERIPH_LIMIT;
        if (cmd_r == CMD_RD_WORD && sp_ok) begin
          rd_nxt = 32'd0;
          st_nxt = ST_DONE;
        end else begin
          rd_nxt = err_pattern(n);
          st_nxt = ST_RANGE;
        end
        state_nxt = S_OUT;
      end

      S_RD: begin
        // address goes out, data comes back next cycle
        state_nxt = S_RDW;
      end

      S_RDW: begin
        rd_nxt[{idx_r, 3'b000} +: 8] = rbyte;
        baddr_nxt = baddr_r + 32'd1;
        idx_nxt   = idx_r + 2'd1;
        state_nxt = last ? S_OUT : S_RD;
      end

      S_WR: begin
        // bytes that land outside the target region are dropped
        fl_we     = use_flash_r && sp_ok;
        sr_we     = !use_flash_r && sp_ok;
        baddr_nxt = baddr_r + 32'd1;
        idx_nxt   = idx_r + 2'd1;
        if (last) begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_r;
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      flash_base_r <= FLASH_BASE_RST;
      sram_base_r  <= SRAM_BASE_RST;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      flash_base_r <= flash_base_nxt;
      sram_base_r  <= sram_base_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    addr_r      <= addr_nxt;
    data_r      <= data_nxt;
    baddr_r     <= baddr_nxt;
    idx_r       <= idx_nxt;
    fit_flash_r <= fit_flash_nxt;
    use_flash_r <= use_flash_nxt;
    rd_r        <= rd_nxt;
    st_r        <= st_nxt;
    out_data_r  <= out_data_nxt;
    out_st_r    <= out_st_nxt;
  end

endmodule

### hdl/fsbm_checker.sv
// port-level checks for the flash/sram bus memory, bound to the top level
module fsbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import fsbm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // in_tready is low right after reset, as the clearing pass starts
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_tready)
    else $error("input taken before stores were cleared");

  // misaligned checked writes give zero data
  a_misalign_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_MISALIGN |-> out_tdata == 32'd0)
    else $error("misaligned status with non-zero data");

  // range errors carry zero or an all-ones pattern
  a_range_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_RANGE |->
      out_tdata == 32'd0 || out_tdata == 32'h0000_00FF ||
      out_tdata == 32'h0000_FFFF || out_tdata == 32'hFFFF_FFFF)
    else $error("range status with bad data pattern");

  // status code never beyond range error
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("status code out of range");

endmodule

bind flash_sram_bus_memory fsbm_checker u_fsbm_checker (.*);

### sim/tb_flash_sram_bus_memory.sv
// self-checking testbench for the flash/sram bus memory over several memory maps
`timescale 1ns / 1ps

module tb_flash_sram_bus_memory;
  import fsbm_pkg::*;

  localparam int FLASH_BYTES = 65536;
  localparam int SRAM_BYTES  = 16384;

  // command codes the block does not define, answered with a range status
  localparam logic [3:0] CMD_UNDEF_LO = 4'd9;
  localparam logic [3:0] CMD_UNDEF_HI = 4'd15;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } outcome_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = '0;   // [31:0] address, [63:32] write_data
  logic [3:0]  in_tuser    = '0;   // [3:0] command
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // [31:0] read_data
  logic [1:0]  out_tuser;          // [1:0] status
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow of both byte stores and of the two base registers
  logic [7:0]  flash_img [FLASH_BYTES];
  logic [7:0]  sram_img  [SRAM_BYTES];
  logic [31:0] flash_org;
  logic [31:0] sram_org;

  // answers still owed by the block, oldest first
  outcome_t    outcome_q [$];
  outcome_t    owed;
  int          fault_count = 0;
  bit          steady      = 1'b0;  // no idling on either side while set
  int          tready_hold = 0;

  flash_sram_bus_memory #(
    .FLASH_BYTES(FLASH_BYTES),
    .SRAM_BYTES (SRAM_BYTES)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // n bytes from addr all inside [base, base+size), with wrap-around
  function automatic bit span_fits(input logic [31:0] addr, input logic [31:0] base,
                                   input int size, input int n);
    logic [31:0] off;
    off = addr - base;
    return off <= 32'(size) - 32'(n);
  endfunction

  // little-endian gather from one store
  function automatic logic [31:0] gather(input bit from_flash, input logic [31:0] off,
                                         input int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++)
      v[8*i +: 8] = from_flash ? flash_img[off + i] : sram_img[off + i];
    return v;
  endfunction

  // a byte is kept only where it lands inside the region
  function automatic void put_sram(input logic [31:0] addr, input logic [7:0] b);
    logic [31:0] off;
    off = addr - sram_org;
    if (off < SRAM_BYTES) sram_img[off] = b;
  endfunction

  function automatic void put_flash(input logic [31:0] addr, input logic [7:0] b);
    logic [31:0] off;
    off = addr - flash_org;
    if (off < FLASH_BYTES) flash_img[off] = b;
  endfunction

  // answer of one access, updating the shadow stores on the way
  function automatic outcome_t access_outcome(input logic [3:0] cmd, input logic [31:0] addr,
                                              input logic [31:0] data);
    outcome_t res;
    int       n;
    res.read_data = '0;
    res.status    = ST_DONE;
    case (cmd)
      CMD_RD_BYTE, CMD_RD_HALF, CMD_RD_WORD: begin
        n = (cmd == CMD_RD_BYTE) ? 1 : (cmd == CMD_RD_HALF) ? 2 : 4;
        // flash wins where the regions overlap
        if (span_fits(addr, flash_org, FLASH_BYTES, n)) begin
          res.read_data = gather(1'b1, addr - flash_org, n);
        end else if (span_fits(addr, sram_org, SRAM_BYTES, n)) begin
          res.read_data = gather(1'b0, addr - sram_org, n);
        end else if (cmd == CMD_RD_WORD && addr >= PERIPH_LOW && addr < PERIPH_END) begin
          res.read_data = '0;
        end else begin
          res.read_data = (n == 1) ? 32'h0000_00FF : (n == 2) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
          res.status    = ST_RANGE;
        end
      end
      CMD_WR_BYTE, CMD_WR_HALF, CMD_WR_WORD: begin
        n = (cmd == CMD_WR_BYTE) ? 1 : (cmd == CMD_WR_HALF) ? 2 : 4;
        for (int i = 0; i < n; i++) put_sram(addr + i, data[8*i +: 8]);
      end
      CMD_CK_HALF, CMD_CK_WORD: begin
        n = (cmd == CMD_CK_HALF) ? 2 : 4;
        if ((addr & 32'(n - 1)) != 0) begin
          res.status = ST_MISALIGN;
        end else if (!span_fits(addr, sram_org, SRAM_BYTES, n)) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = 0; i < n; i++) put_sram(addr + i, data[8*i +: 8]);
        end
      end
      CMD_PROG: begin
        for (int i = 0; i < 4; i++) put_flash(addr + i, data[8*i +: 8]);
      end
      default: res.status = ST_RANGE;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- random picks

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [3:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 4'($urandom_range(CMD_RD_BYTE, CMD_RD_WORD));
    if (r < 70) return 4'($urandom_range(CMD_WR_BYTE, CMD_WR_WORD));
    if (r < 85) return 4'($urandom_range(CMD_CK_HALF, CMD_CK_WORD));
    if (r < 95) return CMD_PROG;
    return 4'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
  endfunction

  // offset near either end of a region, a few bytes past it included,
  // so that writes and reads keep meeting the same bytes
  function automatic logic [31:0] rim_offset(input int size);
    if ($urandom_range(0, 1)) return 32'($urandom_range(0, 75)) - 32'd6;
    return 32'(size) - 32'd70 + 32'($urandom_range(0, 76));
  endfunction

  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return flash_org + rim_offset(FLASH_BYTES);
    if (r < 60) return sram_org + rim_offset(SRAM_BYTES);
    if (r < 70) begin
      // peripheral window, its borders and inside
      case ($urandom_range(0, 2))
        0:       return PERIPH_LOW - 32'd4 + 32'($urandom_range(0, 15));
        1:       return PERIPH_END - 32'd8 + 32'($urandom_range(0, 15));
        default: return PERIPH_LOW + 32'($urandom_range(0, PERIPH_LIMIT));
      endcase
    end
    if (r < 80) return $urandom_range(0, 1) ? flash_org + 32'($urandom_range(0, FLASH_BYTES - 1))
                                            : sram_org + 32'($urandom_range(0, SRAM_BYTES - 1));
    return $urandom();
  endfunction

  // ---------------------------------------------------------------- bus drivers

  // result side: random stalls on out_tready, none while steady
  always @(posedge clk) begin
    if (tready_hold > 0) begin
      tready_hold <= tready_hold - 1;
      out_tready  <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      tready_hold <= pick_gap();
      out_tready  <= 1'b0;
    end else begin
      out_tready  <= 1'b1;
    end
  end

  // one access transfer; valid stays high afterwards until the next gap or a drain
  task automatic send_access(input logic [3:0] cmd, input logic [31:0] addr,
                             input logic [31:0] data);
    int gap;
    bit took;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {data, addr};
    // ready is sampled mid-cycle, where it holds the value the next edge sees
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    outcome_q.push_back(access_outcome(cmd, addr, data));
  endtask

  // stop sending and let every owed answer come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup cycle then access cycle; the register takes the value at the access edge
  task automatic write_base(input logic [0:0] sel, input logic [31:0] value);
    bit rdy;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = cfg_pready;
      @(posedge clk);
    end while (!rdy);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == REG_FLASH_BASE) flash_org = value;
    else sram_org = value;
    // the port goes idle before the next transfer
    @(posedge clk);
  endtask

  task automatic apply_map(input logic [31:0] flash_at, input logic [31:0] sram_at);
    write_base(REG_FLASH_BASE, flash_at);
    write_base(REG_SRAM_BASE, sram_at);
  endtask

  // ---------------------------------------------------------------- result check

  // transfer on the result side happens at the next rising edge; check mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t unexpected result: read_data %h status %0d", $time, out_tdata,
                 out_tuser);
        fault_count++;
      end else begin
        owed = outcome_q.pop_front();
        if (out_tdata !== owed.read_data) begin
          $display("%0t read_data mismatch: expected %h actual %h", $time, owed.read_data,
                   out_tdata);
          fault_count++;
        end
        if (out_tuser !== owed.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, owed.status,
                   out_tuser);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // region edges, every command, error patterns, peripheral window, bad codes
  task automatic test_directed_accesses();
    logic [31:0] f;
    logic [31:0] s;
    f = flash_org;
    s = sram_org;
    send_access(CMD_RD_BYTE, f, 32'h0);
    send_access(CMD_RD_WORD, f + FLASH_BYTES - 4, 32'h0);
    send_access(CMD_PROG,    f, 32'h1122_3344);
    send_access(CMD_RD_WORD, f, 32'h0);
    send_access(CMD_RD_HALF, f + 1, 32'h0);                    // unaligned read
    send_access(CMD_PROG,    f + FLASH_BYTES - 2, 32'hA5B6_C7D8); // half lands past flash
    send_access(CMD_RD_HALF, f + FLASH_BYTES - 2, 32'h0);
    send_access(CMD_RD_WORD, f + FLASH_BYTES - 2, 32'h0);     // straddles the end
    send_access(CMD_WR_WORD, s, 32'hDEAD_BEEF);
    send_access(CMD_WR_HALF, s + 4, 32'hFFFF_1234);
    send_access(CMD_WR_BYTE, s + 6, 32'h0000_00AB);
    send_access(CMD_RD_WORD, s + 4, 32'h0);
    send_access(CMD_WR_WORD, s - 2, 32'hCAFE_F00D);           // low half dropped
    send_access(CMD_RD_HALF, s, 32'h0);
    send_access(CMD_CK_HALF, s + 1, 32'h5555_5555);           // misaligned
    send_access(CMD_CK_WORD, s + 2, 32'h5555_5555);           // misaligned
    send_access(CMD_CK_WORD, s + SRAM_BYTES, 32'h5555_5555);  // past sram
    send_access(CMD_CK_WORD, s + SRAM_BYTES - 4, 32'hFFFF_FFFF);
    send_access(CMD_CK_HALF, s + SRAM_BYTES - 2, 32'h0000_8001);
    send_access(CMD_RD_WORD, PERIPH_LOW, 32'h0);
    send_access(CMD_RD_WORD, PERIPH_END - 1, 32'h0);
    send_access(CMD_RD_WORD, PERIPH_END, 32'h0);
    send_access(CMD_RD_BYTE, PERIPH_LOW, 32'h0);              // narrow peripheral read fails
    send_access(CMD_RD_HALF, PERIPH_LOW, 32'h0);
    send_access(CMD_UNDEF_LO, s, 32'hFFFF_FFFF);
    send_access(CMD_UNDEF_HI, 32'hFFFF_FFFF, 32'h0);
    wait_drained();
  endtask

  // random accesses aimed at the region borders, with idle-free stretches now and then
  task automatic run_mixed_accesses(input int count);
    logic [3:0]  cmd;
    logic [31:0] addr;
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      cmd  = pick_command();
      addr = pick_address();
      // most checked writes aligned so they get past the alignment test
      if (cmd == CMD_CK_HALF && $urandom_range(0, 2) != 0) addr[0] = 1'b0;
      if (cmd == CMD_CK_WORD && $urandom_range(0, 2) != 0) addr[1:0] = 2'b00;
      send_access(cmd, addr, $urandom());
    end
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_reset_map();
    run_mixed_accesses(170);
  endtask

  // flash at zero, sram wrapping over the top and overlapping flash
  task automatic test_wrapped_overlap_map();
    apply_map(32'h0000_0000, 32'hFFFF_E000);
    run_mixed_accesses(170);
  endtask

  // flash from the last address, sram over the start of the peripheral window
  task automatic test_top_flash_map();
    apply_map(32'hFFFF_FFFF, PERIPH_LOW);
    run_mixed_accesses(170);
  endtask

  // both regions from the same base, so sram is hidden from reads
  task automatic test_coincident_map();
    apply_map(32'h3FFF_C000, 32'h3FFF_C000);
    run_mixed_accesses(170);
  endtask

  task automatic test_random_map();
    apply_map($urandom(), $urandom());
    run_mixed_accesses(170);
  endtask

  // short bursts, each one answered in full before the next starts
  task automatic test_pause_until_drained();
    apply_map(FLASH_BASE_RST, 32'hFFFF_FFFF);
    for (int g = 0; g < 6; g++) run_mixed_accesses(10);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    foreach (flash_img[i]) flash_img[i] = 8'h00;
    foreach (sram_img[i]) sram_img[i] = 8'h00;
    flash_org = FLASH_BASE_RST;
    sram_org  = SRAM_BASE_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing pass after reset holds in_tready low; the first send waits it out
    test_directed_accesses();
    test_reset_map();
    test_wrapped_overlap_map();
    test_top_flash_map();
    test_coincident_map();
    test_random_map();
    test_pause_until_drained();
    repeat (16) @(posedge clk);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
